>>> hw/rtl/round_robin_node_picker_macros.svh
// Assertion macros used by the round-robin node picker controller.
`ifndef ROUND_ROBIN_NODE_PICKER_MACROS_SVH
`define ROUND_ROBIN_NODE_PICKER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define RRNP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RRNP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RRNP_ASSERT_IMP(lbl, ante, cons, msg)
`define RRNP_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/rrnp_pkg.sv
// Shared types, codes and defaults of the round-robin node picker.
`default_nettype none

package rrnp_pkg;

    localparam int NODES_DEF      = 64;
    localparam int MAX_DECODE_DEF = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFILL_COUNT = 1'd1;

    localparam logic [1:0] REQ_STATUS = 2'd0;
    localparam logic [1:0] REQ_SCHED  = 2'd1;
    localparam logic [1:0] REQ_LIST   = 2'd2;

    localparam logic [1:0] STATUS_PICKED = 2'd0;
    localparam logic [1:0] STATUS_NONE   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  node_slot;
        logic [15:0] total_slots;
        logic [31:0] total_blocks;
        logic [15:0] avail_slots;
        logic [31:0] avail_blocks;
        logic [3:0]  list_pos;
        logic [5:0]  decode_slot;
        logic [4:0]  list_len;
        logic        separate_mode;
        logic        empty_body;
    } rrnp_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] first_node;
        logic [5:0] second_node;
    } rrnp_rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_NODE_RD,
        S_NODE_CHK,
        S_TBL_CHK,
        S_DEC_CHK,
        S_DONE
    } rrnp_state_t;

    typedef enum logic [1:0] {
        RES_KEEP,
        RES_EMPTY,
        RES_NONE,
        RES_PICK
    } rrnp_res_t;

    typedef struct packed {
        logic      clr_step;
        logic      accept;
        logic      start;
        logic      rd_node;
        logic      rd_table;
        logic      rd_dec;
        logic      next;
        logic      commit_hist;
        logic      out_load;
        rrnp_res_t res;
    } rrnp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic in_sched;
        logic in_empty;
        logic in_cnt_zero;
        logic sep_mode;
        logic node_ok;
        logic dec_in_range;
        logic dec_ok;
        logic wrapped;
        logic out_free;
    } rrnp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/round_robin_node_picker.sv
// Top level of the round-robin node picker: controller plus datapath.
//
//  Channel   Signals                          Beat moves when
//  request   req_valid, req_stall, req_data   req_valid && !req_stall
//  result    rsp_valid, rsp_stall, rsp_data   rsp_valid && !rsp_stall
//  config    cfg_we, cfg_index, cfg_data      cfg_we
//
// After reset a clearing pass zeroes the usable, length and decode history tables;
// no request beat is taken then, configuration writes are. Status updates and
// decode-list writes are stored when accepted. A schedule request tries nodes in
// turn, each by a node read and check in single mode, plus a table check and a
// decode check in prefill/decode mode, as the scan sequencer reads one-port tables.
// The result register lets a new request be taken while a result beat is stalled.
`default_nettype none

module round_robin_node_picker #(
    parameter int NODES      = rrnp_pkg::NODES_DEF,
    parameter int MAX_DECODE = rrnp_pkg::MAX_DECODE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  rrnp_pkg::rrnp_req_t             req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output rrnp_pkg::rrnp_rsp_t             rsp_data,
    input  logic                            cfg_we,
    input  logic [rrnp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrnp_pkg::CFG_DATA_W-1:0] cfg_data
);

    rrnp_pkg::rrnp_cmd_t cmd;
    rrnp_pkg::rrnp_sts_t sts;

    rrnp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rrnp_dp #(
        .NODES      (NODES),
        .MAX_DECODE (MAX_DECODE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_data  (req_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/rrnp_dp.sv
// Datapath of the node picker: tables, pointers, configuration and result register.
`default_nettype none

module rrnp_dp #(
    parameter int NODES      = rrnp_pkg::NODES_DEF,
    parameter int MAX_DECODE = rrnp_pkg::MAX_DECODE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rrnp_pkg::rrnp_cmd_t             cmd,
    output rrnp_pkg::rrnp_sts_t             sts,
    input  rrnp_pkg::rrnp_req_t             req_data,
    input  logic                            cfg_we,
    input  logic [rrnp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrnp_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output rrnp_pkg::rrnp_rsp_t             rsp_data
);

    localparam int SW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int KW = (CW > rrnp_pkg::CFG_DATA_W) ? CW : rrnp_pkg::CFG_DATA_W;
    localparam int EW = ((SW > 6) ? SW : 6) + 1;
    localparam int PW = (MAX_DECODE > 1) ? $clog2(MAX_DECODE) : 1;
    localparam int LW = $clog2(MAX_DECODE + 1);
    localparam int EL = ((LW > 5) ? LW : 5) + 1;
    localparam int EP = ((PW > 4) ? PW : 4) + 1;
    localparam int IW = ((PW + 1) > LW) ? (PW + 1) : LW;
    localparam int TD = NODES * (2 ** PW);

    // Per-node stores; the first three are zeroed by the clearing pass after reset.
    logic          usable_mem [NODES];
    logic [LW-1:0] len_mem    [NODES];
    logic [PW:0]   hist_mem   [NODES];
    logic [5:0]    table_mem  [TD];

    logic [rrnp_pkg::CFG_DATA_W-1:0] single_cfg_reg;
    logic [rrnp_pkg::CFG_DATA_W-1:0] prefill_cfg_reg;
    logic [SW-1:0]                   single_ptr_reg;
    logic [SW-1:0]                   prefill_ptr_reg;
    logic [SW-1:0]                   start_reg;
    logic [SW-1:0]                   clr_cnt_reg;
    logic                            mode_reg;
    logic [PW-1:0]                   idx_reg;

    logic          usable_rd_reg;
    logic [LW-1:0] len_rd_reg;
    logic [PW:0]   hist_rd_reg;
    logic [5:0]    tbl_rd_reg;

    logic [1:0] res_status_reg;
    logic [5:0] res_first_reg;
    logic [5:0] res_second_reg;

    logic                rsp_valid_reg;
    rrnp_pkg::rrnp_rsp_t rsp_data_reg;

    logic [KW-1:0]      single_ext;
    logic [KW-1:0]      prefill_ext;
    logic [CW-1:0]      single_cnt;
    logic [CW-1:0]      prefill_cnt;
    logic [SW:0]        single_inc;
    logic [SW:0]        prefill_inc;
    logic [SW-1:0]      single_adv;
    logic [SW-1:0]      prefill_adv;
    logic               mode_sel;
    logic [SW-1:0]      cur_ptr;
    logic [SW-1:0]      adv_ptr;
    logic               slot_ok;
    logic [SW-1:0]      slot_idx;
    logic               pos_ok;
    logic [LW-1:0]      len_sat;
    logic               is_status;
    logic               is_list;
    logic               node_fit;
    logic [IW-1:0]      last_inc;
    logic [PW-1:0]      pick_idx;
    logic [SW-1:0]      dec_idx;
    logic [SW-1:0]      usable_ra;
    logic               out_free;

    // Counts above the table size behave as the table size.
    always_comb
    begin
        single_ext  = KW'(single_cfg_reg);
        prefill_ext = KW'(prefill_cfg_reg);
        single_cnt  = (single_ext > KW'(NODES)) ? CW'(NODES) : CW'(single_ext);
        prefill_cnt = (prefill_ext > KW'(NODES)) ? CW'(NODES) : CW'(prefill_ext);
    end

    // Both pointers advance with wrap from registered state only, so status never
    // depends on a command of the same cycle.
    always_comb
    begin
        single_inc  = {1'b0, single_ptr_reg} + (SW + 1)'(1);
        prefill_inc = {1'b0, prefill_ptr_reg} + (SW + 1)'(1);
        single_adv  = (single_inc >= (SW + 1)'(single_cnt)) ? '0 : single_inc[SW-1:0];
        prefill_adv = (prefill_inc >= (SW + 1)'(prefill_cnt)) ? '0 : prefill_inc[SW-1:0];
    end

    always_comb
    begin
        mode_sel = cmd.accept ? req_data.separate_mode : mode_reg;
        cur_ptr  = mode_sel ? prefill_ptr_reg : single_ptr_reg;
        adv_ptr  = mode_sel ? prefill_adv : single_adv;
    end

    always_comb
    begin
        is_status = cmd.accept && (req_data.req_type == rrnp_pkg::REQ_STATUS);
        is_list   = cmd.accept && (req_data.req_type == rrnp_pkg::REQ_LIST);
        slot_ok   = EW'(req_data.node_slot) < EW'(NODES);
        slot_idx  = SW'(req_data.node_slot);
        pos_ok    = EP'(req_data.list_pos) < EP'(MAX_DECODE);
        len_sat   = (EL'(req_data.list_len) > EL'(MAX_DECODE)) ? LW'(MAX_DECODE)
                                                               : LW'(req_data.list_len);
        node_fit  = (req_data.total_slots != '0) && (req_data.total_blocks != '0) &&
                    (req_data.avail_slots != '0) && (req_data.avail_blocks != '0);
    end

    // Decode position tried next: zero on the first pick, else last plus one with wrap.
    always_comb
    begin
        last_inc = IW'(hist_rd_reg[PW-1:0]) + IW'(1);
        if (!hist_rd_reg[PW])
        begin
            pick_idx = '0;
        end
        else if (last_inc >= IW'(len_rd_reg))
        begin
            pick_idx = '0;
        end
        else
        begin
            pick_idx = PW'(last_inc);
        end
        dec_idx   = SW'(tbl_rd_reg);
        usable_ra = cmd.rd_dec ? dec_idx : cur_ptr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            usable_mem[clr_cnt_reg] <= 1'b0;
        end
        else if (is_status && slot_ok)
        begin
            usable_mem[slot_idx] <= node_fit;
        end
        if (cmd.rd_node || cmd.rd_dec)
        begin
            usable_rd_reg <= usable_mem[usable_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            len_mem[clr_cnt_reg] <= '0;
        end
        else if (is_list && slot_ok)
        begin
            len_mem[slot_idx] <= len_sat;
        end
        if (cmd.rd_node)
        begin
            len_rd_reg <= len_mem[cur_ptr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            hist_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.commit_hist)
        begin
            hist_mem[cur_ptr] <= {1'b1, idx_reg};
        end
        if (cmd.rd_node)
        begin
            hist_rd_reg <= hist_mem[cur_ptr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_list && slot_ok && pos_ok)
        begin
            table_mem[{slot_idx, PW'(req_data.list_pos)}] <= req_data.decode_slot;
        end
        if (cmd.rd_table)
        begin
            tbl_rd_reg <= table_mem[{cur_ptr, pick_idx}];
            idx_reg    <= pick_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_cfg_reg  <= '0;
            prefill_cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rrnp_pkg::CFG_SINGLE_COUNT:  single_cfg_reg  <= cfg_data;
                rrnp_pkg::CFG_PREFILL_COUNT: prefill_cfg_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_ptr_reg  <= '0;
            prefill_ptr_reg <= '0;
            clr_cnt_reg     <= '0;
            mode_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + SW'(1);
            end
            if (cmd.accept)
            begin
                mode_reg <= req_data.separate_mode;
            end
            if (cmd.start || cmd.next)
            begin
                if (mode_sel)
                begin
                    prefill_ptr_reg <= adv_ptr;
                end
                else
                begin
                    single_ptr_reg <= adv_ptr;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            start_reg <= adv_ptr;
        end
        case (cmd.res)
            rrnp_pkg::RES_EMPTY:
            begin
                res_status_reg <= rrnp_pkg::STATUS_EMPTY;
                res_first_reg  <= '0;
                res_second_reg <= '0;
            end
            rrnp_pkg::RES_NONE:
            begin
                res_status_reg <= rrnp_pkg::STATUS_NONE;
                res_first_reg  <= '0;
                res_second_reg <= '0;
            end
            rrnp_pkg::RES_PICK:
            begin
                res_status_reg <= rrnp_pkg::STATUS_PICKED;
                res_first_reg  <= 6'(cur_ptr);
                res_second_reg <= mode_reg ? tbl_rd_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_data_reg.status      <= res_status_reg;
            rsp_data_reg.first_node  <= res_first_reg;
            rsp_data_reg.second_node <= res_second_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        sts.clr_done     = (clr_cnt_reg == SW'(NODES - 1));
        sts.in_sched     = (req_data.req_type == rrnp_pkg::REQ_SCHED);
        sts.in_empty     = req_data.empty_body;
        sts.in_cnt_zero  = ((req_data.separate_mode ? prefill_cnt : single_cnt) == '0);
        sts.sep_mode     = mode_reg;
        sts.node_ok      = usable_rd_reg && (!mode_reg || (len_rd_reg != '0));
        sts.dec_in_range = EW'(tbl_rd_reg) < EW'(NODES);
        sts.dec_ok       = usable_rd_reg;
        sts.wrapped      = ((mode_reg ? prefill_adv : single_adv) == start_reg);
        sts.out_free     = out_free;
    end

endmodule

`default_nettype wire

>>> hw/rtl/rrnp_ctrl.sv
// Controller of the node picker: clearing pass, request sequencing and scan steps.
`default_nettype none

`include "round_robin_node_picker_macros.svh"

module rrnp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  rrnp_pkg::rrnp_sts_t sts,
    output rrnp_pkg::rrnp_cmd_t cmd
);

    rrnp_pkg::rrnp_state_t state_reg;
    rrnp_pkg::rrnp_state_t state_next;
    logic                  miss;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrnp_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.res    = rrnp_pkg::RES_KEEP;
        state_next = state_reg;
        miss       = 1'b0;
        req_stall  = (state_reg != rrnp_pkg::S_IDLE);

        case (state_reg)
            rrnp_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = rrnp_pkg::S_IDLE;
                end
            end
            rrnp_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.in_sched)
                    begin
                        if (sts.in_empty)
                        begin
                            cmd.res    = rrnp_pkg::RES_EMPTY;
                            state_next = rrnp_pkg::S_DONE;
                        end
                        else if (sts.in_cnt_zero)
                        begin
                            cmd.res    = rrnp_pkg::RES_NONE;
                            state_next = rrnp_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            state_next = rrnp_pkg::S_NODE_RD;
                        end
                    end
                end
            end
            rrnp_pkg::S_NODE_RD:
            begin
                cmd.rd_node = 1'b1;
                state_next  = rrnp_pkg::S_NODE_CHK;
            end
            rrnp_pkg::S_NODE_CHK:
            begin
                if (!sts.node_ok)
                begin
                    miss = 1'b1;
                end
                else if (!sts.sep_mode)
                begin
                    cmd.res    = rrnp_pkg::RES_PICK;
                    state_next = rrnp_pkg::S_DONE;
                end
                else
                begin
                    cmd.rd_table = 1'b1;
                    state_next   = rrnp_pkg::S_TBL_CHK;
                end
            end
            rrnp_pkg::S_TBL_CHK:
            begin
                if (!sts.dec_in_range)
                begin
                    miss = 1'b1;
                end
                else
                begin
                    cmd.rd_dec = 1'b1;
                    state_next = rrnp_pkg::S_DEC_CHK;
                end
            end
            rrnp_pkg::S_DEC_CHK:
            begin
                if (sts.dec_ok)
                begin
                    cmd.commit_hist = 1'b1;
                    cmd.res         = rrnp_pkg::RES_PICK;
                    state_next      = rrnp_pkg::S_DONE;
                end
                else
                begin
                    miss = 1'b1;
                end
            end
            rrnp_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rrnp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rrnp_pkg::S_IDLE;
            end
        endcase

        // A failed candidate moves the pointer on; back at the start means no pick.
        if (miss)
        begin
            cmd.next = 1'b1;
            if (sts.wrapped)
            begin
                cmd.res    = rrnp_pkg::RES_NONE;
                state_next = rrnp_pkg::S_DONE;
            end
            else
            begin
                state_next = rrnp_pkg::S_NODE_RD;
            end
        end
    end

    `RRNP_ASSERT_IMP(a_dec_after_tbl, state_reg == rrnp_pkg::S_DEC_CHK, $past(state_reg) == rrnp_pkg::S_TBL_CHK, "decode check not preceded by table read")
    `RRNP_ASSERT_IMP(a_hist_sep_only, cmd.commit_hist, sts.sep_mode && !cmd.next, "decode history written outside a prefill pick")
    `RRNP_ASSERT_NXT(a_done_to_idle, state_reg == rrnp_pkg::S_DONE && sts.out_free, state_reg == rrnp_pkg::S_IDLE, "result beat loaded but controller not idle")

endmodule

`default_nettype wire
